[rtl/core/ccf_pkg.sv]
// Shared types and constants for the 3x3 clamp convolution filter.
// Used by the channel interfaces and every module under rtl/core.
package ccf_pkg;

   localparam int CH_W        = 8;
   localparam int NUM_PORT_CH = 3;
   localparam int PIX_W       = CH_W * NUM_PORT_CH;
   localparam int KSIZE       = 3;
   localparam int WIN_TAPS    = KSIZE * KSIZE;
   localparam int COEF_W      = 16;
   localparam int KROW_W      = COEF_W * KSIZE;
   localparam int DIM_W       = 12;
   localparam int ROW_W       = 11;
   localparam int HEIGHT_CAP  = 2048;
   localparam int DIM_MIN     = 3;
   localparam int PIX_MAX     = 255;
   localparam int PROD_W      = CH_W + 1 + COEF_W;
   localparam int ROWSUM_W    = PROD_W + 2;
   localparam int SUM_W       = ROWSUM_W + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 3;

   localparam int MAX_WIDTH_DEF      = 2048;
   localparam int NUM_CHANNELS_DEF   = 3;
   localparam int COEF_FRAC_BITS_DEF = 12;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_TOP    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_MIDDLE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_BOTTOM = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = CSR_IDX_W'(4);

   typedef struct packed {
      logic [WIN_TAPS-1:0][PIX_W-1:0] pix;
      logic                           last;
   } win_type;

   typedef struct packed {
      logic f1_valid;
      logic f1_fire;
   } front_stat_type;

endpackage

[rtl/core/ccf_chan_if.sv]
// Handshake channels of the 3x3 clamp convolution filter: pixel in, result out, CSR write.
// Depends on ccf_pkg for field widths.
interface ccf_req_if;
   logic                     valid;
   logic                     ready;
   logic [ccf_pkg::CH_W-1:0] pixel_ch0;
   logic [ccf_pkg::CH_W-1:0] pixel_ch1;
   logic [ccf_pkg::CH_W-1:0] pixel_ch2;
   logic                     frame_start;

   modport source (output valid, pixel_ch0, pixel_ch1, pixel_ch2, frame_start, input ready);
   modport sink   (input valid, pixel_ch0, pixel_ch1, pixel_ch2, frame_start, output ready);
endinterface

interface ccf_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [ccf_pkg::CH_W-1:0] filtered_ch0;
   logic [ccf_pkg::CH_W-1:0] filtered_ch1;
   logic [ccf_pkg::CH_W-1:0] filtered_ch2;
   logic                     frame_last;

   modport source (output valid, filtered_ch0, filtered_ch1, filtered_ch2, frame_last,
                   input ready);
   modport sink   (input valid, filtered_ch0, filtered_ch1, filtered_ch2, frame_last,
                   output ready);
endinterface

interface ccf_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ccf_pkg::CSR_IDX_W-1:0] index;
   logic [ccf_pkg::KROW_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/conv3x3_clamp_filter_top.sv]
// Top level of the 3x3 clamp convolution filter: CSR bank, front end, queue, back end.
// Depends on ccf_pkg, the ccf channel interfaces, ccf_front, ccf_queue and ccf_back.
//
// Takes one raster-order pixel word per clock while the result channel keeps up, and gives
// one filtered word for every interior pixel. After the pixel that completes its window, a
// result passes through the line-store read register, the queue slot, the multiply and
// row-sum registers, and the total, clamp and result register. The line store is one
// MAX_WIDTH-entry memory holding both previous rows side by side; its single read and single
// write port set the one-pixel-per-clock figure. It needs no clearing pass. Border pixels
// give no word; frame_last marks the last interior word.
// Write kernel and size registers only while no pixel is in flight.
module conv3x3_clamp_filter_top #(
   parameter int MAX_WIDTH      = ccf_pkg::MAX_WIDTH_DEF,
   parameter int NUM_CHANNELS   = ccf_pkg::NUM_CHANNELS_DEF,
   parameter int COEF_FRAC_BITS = ccf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ccf_req_if.sink   req_ch,
   ccf_rsp_if.source rsp_ch,
   ccf_csr_if.sink   csr_ch
);

   logic [ccf_pkg::KSIZE-1:0][ccf_pkg::KROW_W-1:0] kernel_ff;
   logic [ccf_pkg::DIM_W-1:0]                      width_ff;
   logic [ccf_pkg::DIM_W-1:0]                      height_ff;

   logic                    push_valid, push_ready, pop_valid, pop_ready;
   ccf_pkg::win_type        push_data, pop_data;
   ccf_pkg::front_stat_type front_stat;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= '0;
         width_ff  <= ccf_pkg::RESET_WIDTH;
         height_ff <= ccf_pkg::RESET_HEIGHT;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            ccf_pkg::REG_KERNEL_TOP:    kernel_ff[0] <= csr_ch.data;
            ccf_pkg::REG_KERNEL_MIDDLE: kernel_ff[1] <= csr_ch.data;
            ccf_pkg::REG_KERNEL_BOTTOM: kernel_ff[2] <= csr_ch.data;
            ccf_pkg::REG_IMAGE_WIDTH:   width_ff  <= csr_ch.data[ccf_pkg::DIM_W-1:0];
            ccf_pkg::REG_IMAGE_HEIGHT:  height_ff <= csr_ch.data[ccf_pkg::DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ccf_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .image_width  (width_ff),
      .image_height (height_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data),
      .stat         (front_stat)
   );

   ccf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ccf_back #(
      .NUM_CHANNELS   (NUM_CHANNELS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .kernel    (kernel_ff),
      .rsp_ch    (rsp_ch)
   );

   a_accept_slot_free: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> (!front_stat.f1_valid || front_stat.f1_fire))
      else $error("pixel word taken while front slot occupied");

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (front_stat.f1_valid && !front_stat.f1_fire) |=> front_stat.f1_valid)
      else $error("stalled pixel word dropped from front slot");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result word valid straight after reset");

endmodule

[rtl/core/ccf_front.sv]
// Front end: position counters, two-row line store and 3x3 window assembly.
// Depends on ccf_pkg and ccf_req_if; pushes complete interior windows to ccf_queue.
module ccf_front #(
   parameter int MAX_WIDTH = ccf_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   ccf_req_if.sink                      req_ch,
   input  logic [ccf_pkg::DIM_W-1:0]    image_width,
   input  logic [ccf_pkg::DIM_W-1:0]    image_height,
   output logic                         push_valid,
   input  logic                         push_ready,
   output ccf_pkg::win_type             push_data,
   output ccf_pkg::front_stat_type      stat
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int HW = ccf_pkg::DIM_W;
   localparam int LW = 2 * ccf_pkg::PIX_W;

   logic [LW-1:0] line_mem [MAX_WIDTH];

   logic [AW-1:0]                col_ff, col_in;
   logic [ccf_pkg::ROW_W-1:0]    row_ff, row_in;
   logic                         f1_valid_ff, f1_valid_in;
   logic [ccf_pkg::PIX_W-1:0]    f1_pix_ff;
   logic [AW-1:0]                f1_addr_ff;
   logic                         f1_produce_ff;
   logic                         f1_last_ff;
   logic [LW-1:0]                rd_ff;
   logic                         fwd_ff;
   logic [LW-1:0]                fwd_data_ff;
   logic [ccf_pkg::PIX_W-1:0]    win_ff [6];

   logic [CW-1:0]             w_eff, c0, c1;
   logic [HW-1:0]             h_eff, r0, r1;
   logic                      accept, f1_fire, produce, last;
   logic [LW-1:0]             line, wr_data;
   logic [ccf_pkg::PIX_W-1:0] col [ccf_pkg::KSIZE];
   logic [ccf_pkg::PIX_W-1:0] pix_in;

   always_comb begin
      if (image_width < ccf_pkg::DIM_MIN) begin
         w_eff = CW'(ccf_pkg::DIM_MIN);
      end else if (image_width > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(image_width);
      end
      if (image_height < ccf_pkg::DIM_MIN) begin
         h_eff = HW'(ccf_pkg::DIM_MIN);
      end else if (image_height > ccf_pkg::HEIGHT_CAP) begin
         h_eff = HW'(ccf_pkg::HEIGHT_CAP);
      end else begin
         h_eff = image_height;
      end
   end

   always_comb begin
      c0 = req_ch.frame_start ? '0 : CW'(col_ff);
      r0 = req_ch.frame_start ? '0 : HW'(row_ff);
      if (c0 >= w_eff) begin
         c0 = '0;
         r0 = r0 + 1'b1;
      end
      if (r0 >= h_eff) begin
         r0 = '0;
      end
      produce = (r0 >= HW'(2)) && (c0 >= CW'(2));
      last    = (r0 == h_eff - 1'b1) && (c0 == w_eff - 1'b1);
      c1 = c0 + 1'b1;
      r1 = r0;
      if (c1 >= w_eff) begin
         c1 = '0;
         r1 = r0 + 1'b1;
         if (r1 >= h_eff) begin
            r1 = '0;
         end
      end
      col_in = AW'(c1);
      row_in = ccf_pkg::ROW_W'(r1);
   end

   assign pix_in  = {req_ch.pixel_ch2, req_ch.pixel_ch1, req_ch.pixel_ch0};
   assign f1_fire = f1_valid_ff && (!f1_produce_ff || push_ready);
   assign accept  = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !f1_valid_ff || f1_fire;

   always_comb begin
      f1_valid_in = f1_valid_ff;
      if (accept) begin
         f1_valid_in = 1'b1;
      end else if (f1_fire) begin
         f1_valid_in = 1'b0;
      end
   end

   assign line    = fwd_ff ? fwd_data_ff : rd_ff;
   assign col[0]  = line[ccf_pkg::PIX_W-1:0];
   assign col[1]  = line[LW-1:ccf_pkg::PIX_W];
   assign col[2]  = f1_pix_ff;
   assign wr_data = {f1_pix_ff, line[LW-1:ccf_pkg::PIX_W]};

   always_comb begin
      for (int i = 0; i < ccf_pkg::KSIZE; i++) begin
         push_data.pix[3*i]     = win_ff[2*i];
         push_data.pix[3*i + 1] = win_ff[2*i + 1];
         push_data.pix[3*i + 2] = col[i];
      end
      push_data.last = f1_last_ff;
   end

   assign push_valid    = f1_valid_ff && f1_produce_ff;
   assign stat.f1_valid = f1_valid_ff;
   assign stat.f1_fire  = f1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         f1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         f1_valid_ff <= f1_valid_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            fwd_ff <= f1_fire && (f1_addr_ff == AW'(c0));
         end
         if (f1_fire) begin
            for (int i = 0; i < ccf_pkg::KSIZE; i++) begin
               win_ff[2*i]     <= win_ff[2*i + 1];
               win_ff[2*i + 1] <= col[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_pix_ff     <= pix_in;
         f1_addr_ff    <= AW'(c0);
         f1_produce_ff <= produce;
         f1_last_ff    <= last;
         fwd_data_ff   <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[AW'(c0)];
      end
   end

   always_ff @(posedge clock) begin
      if (f1_fire) begin
         line_mem[f1_addr_ff] <= wr_data;
      end
   end

endmodule

[rtl/core/ccf_queue.sv]
// Two-word queue between window assembly and the multiply-accumulate pipeline.
// Depends on ccf_pkg for the window word type.
module ccf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ccf_pkg::win_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ccf_pkg::win_type pop_data
);

   localparam int PW = $clog2(ccf_pkg::QUEUE_DEPTH);
   localparam int NW = $clog2(ccf_pkg::QUEUE_DEPTH + 1);

   ccf_pkg::win_type slot_ff [ccf_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != NW'(ccf_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(ccf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(ccf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/ccf_back.sv]
// Back end: per-channel 3x3 multiply, row sums, total, clamp and result register.
// Depends on ccf_pkg and ccf_rsp_if; takes windows from ccf_queue.
module ccf_back #(
   parameter int NUM_CHANNELS   = ccf_pkg::NUM_CHANNELS_DEF,
   parameter int COEF_FRAC_BITS = ccf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           pop_valid,
   output logic                                           pop_ready,
   input  ccf_pkg::win_type                               pop_data,
   input  logic [ccf_pkg::KSIZE-1:0][ccf_pkg::KROW_W-1:0] kernel,
   ccf_rsp_if.source                                      rsp_ch
);

   localparam int NCH  = ccf_pkg::NUM_PORT_CH;
   localparam int K    = ccf_pkg::KSIZE;
   localparam int SH_W = ccf_pkg::SUM_W - COEF_FRAC_BITS;

   logic signed [ccf_pkg::PROD_W-1:0]   b1_prod_ff [NCH][K][K];
   logic signed [ccf_pkg::PROD_W-1:0]   prod_in    [NCH][K][K];
   logic signed [ccf_pkg::ROWSUM_W-1:0] b2_row_ff  [NCH][K];
   logic signed [ccf_pkg::ROWSUM_W-1:0] row_in     [NCH][K];
   logic signed [ccf_pkg::SUM_W-1:0]    total      [NCH];
   logic [ccf_pkg::CH_W-1:0]            res_in     [NCH];
   logic [ccf_pkg::CH_W-1:0]            res_ff     [NCH];
   logic                                b1_valid_ff, b2_valid_ff, out_valid_ff;
   logic                                b1_last_ff, b2_last_ff, out_last_ff;
   logic                                b1_en, b2_en, out_en;

   assign out_en    = !out_valid_ff || rsp_ch.ready;
   assign b2_en     = !b2_valid_ff || out_en;
   assign b1_en     = !b1_valid_ff || b2_en;
   assign pop_ready = b1_en;

   always_comb begin
      logic signed [ccf_pkg::PROD_W-1:0] pv, cv;
      for (int ch = 0; ch < NCH; ch++) begin
         for (int i = 0; i < K; i++) begin
            for (int k = 0; k < K; k++) begin
               pv = $signed({{(ccf_pkg::PROD_W - ccf_pkg::CH_W){1'b0}},
                             pop_data.pix[K*i + k][ccf_pkg::CH_W*ch +: ccf_pkg::CH_W]});
               cv = ccf_pkg::PROD_W'($signed(kernel[i][ccf_pkg::COEF_W*k +: ccf_pkg::COEF_W]));
               prod_in[ch][i][k] = (ch < NUM_CHANNELS) ? pv * cv : '0;
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         for (int i = 0; i < K; i++) begin
            row_in[ch][i] = b1_prod_ff[ch][i][0] + b1_prod_ff[ch][i][1] + b1_prod_ff[ch][i][2];
         end
      end
   end

   always_comb begin
      logic [SH_W-1:0] shv;
      for (int ch = 0; ch < NCH; ch++) begin
         total[ch] = b2_row_ff[ch][0] + b2_row_ff[ch][1] + b2_row_ff[ch][2];
         shv = total[ch][ccf_pkg::SUM_W-1:COEF_FRAC_BITS];
         if (total[ch] <= 0) begin
            res_in[ch] = '0;
         end else if (shv > SH_W'(ccf_pkg::PIX_MAX)) begin
            res_in[ch] = ccf_pkg::CH_W'(ccf_pkg::PIX_MAX);
         end else begin
            res_in[ch] = shv[ccf_pkg::CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (b1_en) begin
            b1_valid_ff <= pop_valid;
         end
         if (b2_en) begin
            b2_valid_ff <= b1_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= b2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b1_en) begin
         b1_prod_ff <= prod_in;
         b1_last_ff <= pop_data.last;
      end
      if (b2_en) begin
         b2_row_ff  <= row_in;
         b2_last_ff <= b1_last_ff;
      end
      if (out_en) begin
         res_ff      <= res_in;
         out_last_ff <= b2_last_ff;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.filtered_ch0 = res_ff[0];
   assign rsp_ch.filtered_ch1 = res_ff[1];
   assign rsp_ch.filtered_ch2 = res_ff[2];
   assign rsp_ch.frame_last   = out_last_ff;

endmodule

[sim/ccf_result_checker.sv]
// Result checker for the 3x3 clamp convolution filter: watches the pixel, result and CSR
// channels, predicts each filtered word and compares it with the word the block returns.
// Depends on ccf_pkg and the ccf channel interfaces.
module ccf_result_checker (
   input  logic clock,
   input  logic reset,
   ccf_req_if   req_ch,
   ccf_rsp_if   rsp_ch,
   ccf_csr_if   csr_ch,
   output int   fail_count,
   output int   pending_words,
   output int   words_checked
);

   typedef struct packed {
      logic [ccf_pkg::CH_W-1:0] ch0;
      logic [ccf_pkg::CH_W-1:0] ch1;
      logic [ccf_pkg::CH_W-1:0] ch2;
      logic                     last;
   } filt_word_type;

   logic [ccf_pkg::KSIZE-1:0][ccf_pkg::KROW_W-1:0] kernel_rows;
   logic [ccf_pkg::DIM_W-1:0]                      width_reg;
   logic [ccf_pkg::DIM_W-1:0]                      height_reg;
   logic [ccf_pkg::PIX_W-1:0] row_prev  [ccf_pkg::MAX_WIDTH_DEF];
   logic [ccf_pkg::PIX_W-1:0] row_prev2 [ccf_pkg::MAX_WIDTH_DEF];
   logic [ccf_pkg::PIX_W-1:0] win_regs  [2*ccf_pkg::KSIZE];
   int unsigned               col_cnt;
   int unsigned               row_cnt;
   filt_word_type             filtered_due [$];

   function automatic longint tap_sum(
      input logic [ccf_pkg::WIN_TAPS-1:0][ccf_pkg::PIX_W-1:0] taps, input int ch);
      longint acc;
      int     t;
      acc = 0;
      for (t = 0; t < ccf_pkg::WIN_TAPS; t++)
         acc += longint'(taps[t][ccf_pkg::CH_W*ch +: ccf_pkg::CH_W])
                * longint'($signed(kernel_rows[t / ccf_pkg::KSIZE]
                                   [ccf_pkg::COEF_W*(t % ccf_pkg::KSIZE) +: ccf_pkg::COEF_W]));
      return acc;
   endfunction

   function automatic logic [ccf_pkg::CH_W-1:0] clamp_to_byte(input longint acc);
      longint q;
      if (acc <= 0) return '0;
      q = acc >>> ccf_pkg::COEF_FRAC_BITS_DEF;
      if (q > ccf_pkg::PIX_MAX) return ccf_pkg::CH_W'(ccf_pkg::PIX_MAX);
      return q[ccf_pkg::CH_W-1:0];
   endfunction

   task automatic write_register(input logic [ccf_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [ccf_pkg::KROW_W-1:0] val);
      case (idx)
         ccf_pkg::REG_KERNEL_TOP:    kernel_rows[0] = val;
         ccf_pkg::REG_KERNEL_MIDDLE: kernel_rows[1] = val;
         ccf_pkg::REG_KERNEL_BOTTOM: kernel_rows[2] = val;
         ccf_pkg::REG_IMAGE_WIDTH:   width_reg      = val[ccf_pkg::DIM_W-1:0];
         ccf_pkg::REG_IMAGE_HEIGHT:  height_reg     = val[ccf_pkg::DIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic filter_pixel(input logic [ccf_pkg::PIX_W-1:0] pix, input logic fs);
      int unsigned                                      w, h, c, r, i;
      logic [ccf_pkg::PIX_W-1:0]                        col [ccf_pkg::KSIZE];
      logic [ccf_pkg::WIN_TAPS-1:0][ccf_pkg::PIX_W-1:0] taps;
      filt_word_type                                    word;
      w = width_reg;
      h = height_reg;
      if (w < ccf_pkg::DIM_MIN) w = ccf_pkg::DIM_MIN;
      if (w > ccf_pkg::MAX_WIDTH_DEF) w = ccf_pkg::MAX_WIDTH_DEF;
      if (h < ccf_pkg::DIM_MIN) h = ccf_pkg::DIM_MIN;
      if (h > ccf_pkg::HEIGHT_CAP) h = ccf_pkg::HEIGHT_CAP;
      if (fs) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      c = col_cnt;
      r = row_cnt;
      col[0] = row_prev2[c];
      col[1] = row_prev[c];
      col[2] = pix;
      for (i = 0; i < ccf_pkg::KSIZE; i++) begin
         taps[ccf_pkg::KSIZE*i]     = win_regs[2*i];
         taps[ccf_pkg::KSIZE*i + 1] = win_regs[2*i + 1];
         taps[ccf_pkg::KSIZE*i + 2] = col[i];
      end
      if (r >= 2 && c >= 2) begin
         word.ch0  = clamp_to_byte(tap_sum(taps, 0));
         word.ch1  = clamp_to_byte(tap_sum(taps, 1));
         word.ch2  = clamp_to_byte(tap_sum(taps, 2));
         word.last = (r == h - 1) && (c == w - 1);
         filtered_due.push_back(word);
      end
      for (i = 0; i < ccf_pkg::KSIZE; i++) begin
         win_regs[2*i]     = win_regs[2*i + 1];
         win_regs[2*i + 1] = col[i];
      end
      row_prev2[c] = row_prev[c];
      row_prev[c]  = pix;
      col_cnt = c + 1;
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt = r + 1;
         if (row_cnt >= h) row_cnt = 0;
      end
   endtask

   task automatic check_field(input string name, input logic [ccf_pkg::CH_W-1:0] want,
                              input logic [ccf_pkg::CH_W-1:0] got, inout int bad);
      if (got !== want) begin
         bad++;
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      filt_word_type want, got;
      int            bad, i;
      if (reset) begin
         kernel_rows = '0;
         width_reg   = ccf_pkg::RESET_WIDTH;
         height_reg  = ccf_pkg::RESET_HEIGHT;
         for (i = 0; i < 2*ccf_pkg::KSIZE; i++) win_regs[i] = '0;
         col_cnt = 0;
         row_cnt = 0;
         filtered_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.ch0  = rsp_ch.filtered_ch0;
            got.ch1  = rsp_ch.filtered_ch1;
            got.ch2  = rsp_ch.filtered_ch2;
            got.last = rsp_ch.frame_last;
            if (filtered_due.size() == 0) begin
               $display("%0t unexpected result word: expected none, actual %0h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = filtered_due.pop_front();
               bad  = 0;
               check_field("filtered_ch0", want.ch0, got.ch0, bad);
               check_field("filtered_ch1", want.ch1, got.ch1, bad);
               check_field("filtered_ch2", want.ch2, got.ch2, bad);
               check_field("frame_last", ccf_pkg::CH_W'(want.last),
                           ccf_pkg::CH_W'(got.last), bad);
               if (bad != 0) fail_count <= fail_count + 1;
               words_checked <= words_checked + 1;
            end
         end
         if (csr_ch.valid && csr_ch.ready) write_register(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready)
            filter_pixel({req_ch.pixel_ch2, req_ch.pixel_ch1, req_ch.pixel_ch0},
                         req_ch.frame_start);
      end
      pending_words <= filtered_due.size();
   end

endmodule

[sim/conv3x3_clamp_filter_top_test.sv]
// Testbench top for the 3x3 clamp convolution filter: clock, reset, pixel and CSR stimulus,
// a randomly stalling result receiver, a watchdog and the verdict.
// Depends on ccf_pkg, the ccf channel interfaces, the block and ccf_result_checker.
module conv3x3_clamp_filter_top_test;

   localparam int DRAIN_CYCLES    = 12;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT     = 5000;
   localparam int RANDOM_ITEMS    = 220;
   localparam int UPPER_W         = ccf_pkg::KROW_W - ccf_pkg::DIM_W;

   localparam logic [ccf_pkg::CSR_IDX_W-1:0] REG_UNUSED = ccf_pkg::CSR_IDX_W'(7);
   localparam logic [ccf_pkg::COEF_W-1:0]    COEF_ZERO  = 16'h0000;
   localparam logic [ccf_pkg::COEF_W-1:0]    COEF_ONE   = 16'h1000;
   localparam logic [ccf_pkg::COEF_W-1:0]    COEF_MAX   = 16'h7FFF;
   localparam logic [ccf_pkg::COEF_W-1:0]    COEF_MIN   = 16'h8000;

   typedef enum int {PAT_RANDOM, PAT_ONES, PAT_ZEROS, PAT_EXTREME} pixel_pattern_type;
   typedef enum int {FRAME_CLEAN, FRAME_CUT, FRAME_RESTART} frame_kind_type;

   logic clock = 1'b0;
   logic reset;

   ccf_req_if req_ch ();
   ccf_rsp_if rsp_ch ();
   ccf_csr_if csr_ch ();

   int fail_count;
   int pending_words;
   int words_checked;
   int stall_cycles;
   int hold_requests;
   int holds_started;
   int width_eff;
   int height_eff;
   int pix_sent;
   int csr_sent;
   int settings;
   bit req_gaps;

   conv3x3_clamp_filter_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ccf_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_checked (words_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
   endfunction

   function automatic logic [ccf_pkg::COEF_W-1:0] rand_coef();
      case ($urandom_range(0, 3))
         0: return ccf_pkg::COEF_W'($urandom());
         1: return ccf_pkg::COEF_W'($urandom_range(0, 'h400));
         2: return ccf_pkg::COEF_W'(0 - int'($urandom_range(0, 'h300)));
         default: begin
            case ($urandom_range(0, 2))
               0: return COEF_MAX;
               1: return COEF_MIN;
               default: return COEF_ZERO;
            endcase
         end
      endcase
   endfunction

   function automatic logic [ccf_pkg::KROW_W-1:0] rand_krow();
      return {rand_coef(), rand_coef(), rand_coef()};
   endfunction

   function automatic logic [UPPER_W-1:0] rand_upper();
      return UPPER_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [ccf_pkg::DIM_W-1:0] rand_dim();
      case ($urandom_range(0, 9))
         8: return ccf_pkg::DIM_W'($urandom_range(0, 2));
         9: return ccf_pkg::DIM_W'($urandom_range(11, 14));
         default: return ccf_pkg::DIM_W'($urandom_range(3, 10));
      endcase
   endfunction

   function automatic int dim_in_range(input logic [ccf_pkg::DIM_W-1:0] d, input int cap);
      if (d < ccf_pkg::DIM_MIN) return ccf_pkg::DIM_MIN;
      if (d > cap) return cap;
      return d;
   endfunction

   function automatic logic [ccf_pkg::CH_W-1:0] pattern_byte(input pixel_pattern_type pat);
      case (pat)
         PAT_ONES:    return 8'hFF;
         PAT_ZEROS:   return 8'h00;
         PAT_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default:     return ccf_pkg::CH_W'($urandom());
      endcase
   endfunction

   function automatic pixel_pattern_type pick_pattern();
      case ($urandom_range(0, 9))
         0: return PAT_ONES;
         1: return PAT_ZEROS;
         2: return PAT_EXTREME;
         default: return PAT_RANDOM;
      endcase
   endfunction

   function automatic frame_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return FRAME_CLEAN;
      if (r < 17) return FRAME_CUT;
      return FRAME_RESTART;
   endfunction

   task automatic write_reg(input logic [ccf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ccf_pkg::KROW_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      csr_sent++;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [ccf_pkg::KROW_W-1:0] k_top, k_mid, k_bot,
                                input logic [ccf_pkg::DIM_W-1:0] w_raw, h_raw);
      write_reg(ccf_pkg::REG_KERNEL_TOP, k_top);
      write_reg(ccf_pkg::REG_KERNEL_MIDDLE, k_mid);
      write_reg(ccf_pkg::REG_KERNEL_BOTTOM, k_bot);
      write_reg(ccf_pkg::REG_IMAGE_WIDTH, {rand_upper(), w_raw});
      write_reg(ccf_pkg::REG_IMAGE_HEIGHT, {rand_upper(), h_raw});
      width_eff  = dim_in_range(w_raw, ccf_pkg::MAX_WIDTH_DEF);
      height_eff = dim_in_range(h_raw, ccf_pkg::HEIGHT_CAP);
      settings++;
   endtask

   task automatic send_pixel(input logic [ccf_pkg::CH_W-1:0] p0, p1, p2, input logic fs);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.pixel_ch0   <= p0;
      req_ch.pixel_ch1   <= p1;
      req_ch.pixel_ch2   <= p2;
      req_ch.frame_start <= fs;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pix_sent++;
   endtask

   task automatic send_frame(input int npix, input pixel_pattern_type pat,
                             input bit with_start, input frame_kind_type kind);
      int n, stop_at, restart_at;
      stop_at    = npix;
      restart_at = -1;
      if (kind == FRAME_CUT) stop_at = $urandom_range(1, npix - 1);
      if (kind == FRAME_RESTART) restart_at = $urandom_range(1, npix - 1);
      for (n = 0; n < stop_at; n++)
         send_pixel(pattern_byte(pat), pattern_byte(pat), pattern_byte(pat),
                    (n == 0 && with_start) || n == restart_at);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Watchdog: no handshake for %0d cycles at %0t", stall_cycles, $time);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (holds_started != hold_requests) begin
            rsp_ch.ready  <= 1'b0;
            holds_started <= holds_started + 1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20)) @(posedge clock);
            if ($urandom_range(0, 1) == 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap_len()) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int                f, nframes, base;
      bit                need_start, first;
      frame_kind_type    kind;
      pixel_pattern_type pat;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.pixel_ch0   <= '0;
      req_ch.pixel_ch1   <= '0;
      req_ch.pixel_ch2   <= '0;
      req_ch.frame_start <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= '0;
      csr_ch.data        <= '0;
      req_gaps           = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings at 640 wide: part of the first row, an unused index written first
      write_reg(REG_UNUSED, ccf_pkg::KROW_W'({$urandom(), $urandom()}));
      send_frame(24, PAT_RANDOM, 1'b1, FRAME_CLEAN);
      drain();

      apply_setting({3{COEF_ZERO}}, {COEF_ZERO, COEF_ONE, COEF_ZERO}, {3{COEF_ZERO}},
                    ccf_pkg::DIM_W'(3), ccf_pkg::DIM_W'(3));
      send_frame(width_eff * height_eff, PAT_EXTREME, 1'b1, FRAME_CLEAN);
      drain();
      apply_setting({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}},
                    ccf_pkg::DIM_W'(3), ccf_pkg::DIM_W'(3));
      send_frame(width_eff * height_eff, PAT_ONES, 1'b1, FRAME_CLEAN);
      drain();
      // sizes below range act as 3; frame follows on without a start marker
      apply_setting({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}},
                    ccf_pkg::DIM_W'(2), ccf_pkg::DIM_W'(0));
      send_frame(width_eff * height_eff, PAT_ONES, 1'b0, FRAME_CLEAN);
      drain();

      // sizes above range: send only the start of each frame
      req_gaps = 1'b1;
      apply_setting(rand_krow(), rand_krow(), rand_krow(), 12'hFFF, ccf_pkg::DIM_W'(3));
      send_frame(40, PAT_RANDOM, 1'b1, FRAME_CLEAN);
      drain();
      apply_setting(rand_krow(), rand_krow(), rand_krow(), ccf_pkg::DIM_W'(3), 12'hFFF);
      send_frame(3 * 20, PAT_RANDOM, 1'b1, FRAME_CLEAN);
      drain();

      first = 1'b1;
      base  = pix_sent;
      while (pix_sent - base < RANDOM_ITEMS) begin
         if (first) begin
            req_gaps = 1'b0;
            apply_setting(rand_krow(), rand_krow(), rand_krow(),
                          ccf_pkg::DIM_W'(8), ccf_pkg::DIM_W'(8));
            hold_requests <= hold_requests + 1;
            @(posedge clock);
            while (holds_started != hold_requests) @(posedge clock);
         end else begin
            req_gaps = ($urandom_range(0, 3) != 0);
            apply_setting(rand_krow(), rand_krow(), rand_krow(), rand_dim(), rand_dim());
         end
         need_start = 1'b1;
         nframes    = $urandom_range(1, 3);
         for (f = 0; f < nframes; f++) begin
            kind = first ? FRAME_CLEAN : pick_kind();
            pat  = pick_pattern();
            send_frame(width_eff * height_eff, pat, need_start || $urandom_range(0, 3) == 0,
                       kind);
            need_start = (kind != FRAME_CLEAN);
         end
         drain();
         first = 1'b0;
      end

      $display("Run covered %0d pixel words, %0d register writes over %0d settings and %0d %s",
               pix_sent, csr_sent, settings, words_checked, "checked result words:");
      $display("3x3 to 14-wide frames, clamped sizes, broken frames and a long hold-off");
      if (fail_count == 0 && pending_words == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
